// File: design/v3alu_pkg.sv
package v3alu_pkg;

    localparam logic [3:0] OP_ADD       = 4'd0;
    localparam logic [3:0] OP_SUB       = 4'd1;
    localparam logic [3:0] OP_CROSS     = 4'd2;
    localparam logic [3:0] OP_DOT       = 4'd3;
    localparam logic [3:0] OP_DIST      = 4'd4;
    localparam logic [3:0] OP_REFLECT   = 4'd5;
    localparam logic [3:0] OP_SCALE     = 4'd6;
    localparam logic [3:0] OP_UNIT      = 4'd7;
    localparam logic [3:0] OP_UNIT_DIFF = 4'd8;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] scalar;
    } t_req;

    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic signed [31:0] res_z;
        logic               overflow;
        logic               div_zero;
    } t_res;

    // returns {saturated, value}
    function automatic logic [32:0] sat32(input logic signed [65:0] v);
        logic [32:0] r;
        if (v > 66'sd2147483647) begin
            r = {1'b1, 32'h7fff_ffff};
        end else if (v < -66'sd2147483648) begin
            r = {1'b1, 32'h8000_0000};
        end else begin
            r = {1'b0, v[31:0]};
        end
        return r;
    endfunction

endpackage

// File: design/vector3_alu_core.sv
// Three-component vector unit in signed fixed point (FRAC_BITS fractional bits).
// Takes one request every cycle while o_ready is high and returns one result per
// request, in order. The pipeline (Q16.16 by default) has six front stages for sums,
// products and the reflection, a 32-stage square root that resolves one root
// bit per stage, FRAC_BITS + 1 divider stages that resolve one quotient bit
// per stage, and the output register. A stall on the output freezes the whole
// pipeline; o_ready is low only while the output holds an untaken result.
module vector3_alu_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  v3alu_pkg::t_req   i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output v3alu_pkg::t_res   o_res
);
    import v3alu_pkg::*;

    localparam int NSQ  = 32;
    localparam int FS   = 6;
    localparam int DS   = FS + NSQ;
    localparam int NDIV = FRAC_BITS + 1;
    localparam int LS   = DS + NDIV;
    localparam int NST  = LS + 1;
    localparam int QW   = FRAC_BITS + 1;

    typedef struct packed {
        logic [3:0]           op;
        logic [2:0][31:0]     a;
        logic [2:0][31:0]     b;
        logic [2:0][31:0]     v;
        logic [2:0][31:0]     res;
        logic [31:0]          s;
        logic [31:0]          k;
        logic [31:0]          t;
        logic                 ov;
        logic                 dz;
        logic [5:0][63:0]     p;
        logic [2:0][63:0]     q;
        logic [63:0]          n;
        logic [63:0]          root;
        logic [2:0][33:0]     rem;
        logic [2:0][QW-1:0]   quo;
    } t_ctx;

    t_ctx r_pipe [NST];
    t_ctx n_pipe [NST];
    logic r_vld  [NST];
    logic adv;

    assign adv     = !r_vld[NST-1] || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NST; i++) r_vld[i] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_valid;
            for (int i = 1; i < NST; i++) r_vld[i] <= r_vld[i-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int i = 0; i < NST; i++) r_pipe[i] <= n_pipe[i];
        end
    end

    // stage 0: sums and saturated differences
    always_comb begin
        t_ctx               c;
        logic signed [32:0] sm;
        logic signed [32:0] df;
        logic [2:0][32:0]   sa;
        logic [2:0][32:0]   sd;
        c      = '0;
        c.op   = i_req.req_type;
        c.a[0] = i_req.a_x;
        c.a[1] = i_req.a_y;
        c.a[2] = i_req.a_z;
        c.b[0] = i_req.b_x;
        c.b[1] = i_req.b_y;
        c.b[2] = i_req.b_z;
        c.s    = i_req.scalar;
        c.v    = c.a;
        for (int i = 0; i < 3; i++) begin
            sm    = 33'($signed(c.a[i])) + 33'($signed(c.b[i]));
            df    = 33'($signed(c.a[i])) - 33'($signed(c.b[i]));
            sa[i] = sat32(66'(sm));
            sd[i] = sat32(66'(df));
        end
        unique case (c.op)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) c.res[i] = sa[i][31:0];
                c.ov = sa[0][32] | sa[1][32] | sa[2][32];
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) c.res[i] = sd[i][31:0];
                c.ov = sd[0][32] | sd[1][32] | sd[2][32];
            end
            OP_DIST, OP_UNIT_DIFF: begin
                for (int i = 0; i < 3; i++) c.v[i] = sd[i][31:0];
                c.ov = sd[0][32] | sd[1][32] | sd[2][32];
            end
            default: begin
            end
        endcase
        n_pipe[0] = c;
    end

    // stage 1: six products
    always_comb begin
        t_ctx                    c;
        logic signed [5:0][31:0] ml;
        logic signed [5:0][31:0] mr;
        logic signed [63:0]      pr;
        c = r_pipe[0];
        for (int i = 0; i < 3; i++) begin
            ml[i]   = c.a[i];
            mr[i]   = c.b[i];
            ml[i+3] = c.v[i];
            mr[i+3] = c.v[i];
        end
        if (c.op == OP_CROSS) begin
            ml[0] = c.a[1]; mr[0] = c.b[2];
            ml[1] = c.b[1]; mr[1] = c.a[2];
            ml[2] = c.a[2]; mr[2] = c.b[0];
            ml[3] = c.b[2]; mr[3] = c.a[0];
            ml[4] = c.a[0]; mr[4] = c.b[1];
            ml[5] = c.b[0]; mr[5] = c.a[1];
        end else if (c.op == OP_SCALE) begin
            for (int i = 0; i < 3; i++) mr[i] = c.s;
        end
        for (int i = 0; i < 6; i++) begin
            pr     = $signed(ml[i]) * $signed(mr[i]);
            c.p[i] = pr;
        end
        n_pipe[1] = c;
    end

    // stage 2: truncate, combine, sum of squares
    always_comb begin
        t_ctx                    c;
        logic signed [5:0][63:0] tr;
        logic [32:0]             sv;
        logic [2:0][32:0]        sx;
        c = r_pipe[1];
        for (int i = 0; i < 6; i++) tr[i] = $signed(c.p[i]) >>> FRAC_BITS;
        sv = sat32(66'($signed(tr[0])) + 66'($signed(tr[1])) + 66'($signed(tr[2])));
        sx = '0;
        c.n    = c.p[3] + c.p[4] + c.p[5];
        c.root = '0;
        unique case (c.op)
            OP_CROSS: begin
                sx[0] = sat32(66'($signed(tr[0])) - 66'($signed(tr[1])));
                sx[1] = sat32(66'($signed(tr[2])) - 66'($signed(tr[3])));
                sx[2] = sat32(66'($signed(tr[4])) - 66'($signed(tr[5])));
                for (int i = 0; i < 3; i++) c.res[i] = sx[i][31:0];
                c.ov = sx[0][32] | sx[1][32] | sx[2][32];
            end
            OP_DOT: begin
                c.res[0] = sv[31:0];
                c.ov     = sv[32];
            end
            OP_REFLECT: begin
                c.k  = sv[31:0];
                c.ov = sv[32];
            end
            OP_SCALE: begin
                for (int i = 0; i < 3; i++) sx[i] = sat32(66'($signed(tr[i])));
                for (int i = 0; i < 3; i++) c.res[i] = sx[i][31:0];
                c.ov = sx[0][32] | sx[1][32] | sx[2][32];
            end
            default: begin
            end
        endcase
        n_pipe[2] = c;
    end

    // stage 3: t = -2k
    always_comb begin
        t_ctx        c;
        logic [32:0] st;
        c  = r_pipe[2];
        st = sat32(66'sd0 - (66'($signed(c.k)) <<< 1));
        if (c.op == OP_REFLECT) begin
            c.t  = st[31:0];
            c.ov = c.ov | st[32];
        end
        n_pipe[3] = c;
    end

    // stage 4: b * t
    always_comb begin
        t_ctx               c;
        logic signed [31:0] ml;
        logic signed [31:0] mr;
        logic signed [63:0] pr;
        c  = r_pipe[3];
        mr = c.t;
        for (int i = 0; i < 3; i++) begin
            ml     = c.b[i];
            pr     = ml * mr;
            c.q[i] = pr;
        end
        n_pipe[4] = c;
    end

    // stage 5: reflected components
    always_comb begin
        t_ctx             c;
        logic [2:0][32:0] sx;
        c = r_pipe[4];
        for (int i = 0; i < 3; i++) begin
            sx[i] = sat32((66'($signed(c.q[i])) >>> FRAC_BITS) + 66'($signed(c.a[i])));
        end
        if (c.op == OP_REFLECT) begin
            for (int i = 0; i < 3; i++) c.res[i] = sx[i][31:0];
            c.ov = c.ov | sx[0][32] | sx[1][32] | sx[2][32];
        end
        n_pipe[5] = c;
    end

    // square root, one result bit per stage
    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * g);
        always_comb begin
            t_ctx        c;
            logic [63:0] tmp;
            c   = r_pipe[FS+g-1];
            tmp = c.root + SQ_BIT;
            if (c.n >= tmp) begin
                c.n    = c.n - tmp;
                c.root = (c.root >> 1) + SQ_BIT;
            end else begin
                c.root = c.root >> 1;
            end
            n_pipe[FS+g] = c;
        end
    end

    // |v| * 2^FRAC_BITS / length, one quotient bit per stage; |v| <= length
    for (genvar j = 0; j < NDIV; j++) begin : g_div
        always_comb begin
            t_ctx        c;
            logic [33:0] len;
            logic [33:0] r;
            logic [31:0] mag;
            c   = r_pipe[DS+j-1];
            len = c.root[33:0];
            for (int i = 0; i < 3; i++) begin
                mag = c.v[i][31] ? 32'd0 - c.v[i] : c.v[i];
                if (j == 0) begin
                    r = {2'b00, mag};
                end else begin
                    r = {c.rem[i][32:0], 1'b0};
                end
                if (r >= len) begin
                    c.rem[i] = r - len;
                    c.quo[i] = {c.quo[i][QW-2:0], 1'b1};
                end else begin
                    c.rem[i] = r;
                    c.quo[i] = {c.quo[i][QW-2:0], 1'b0};
                end
            end
            n_pipe[DS+j] = c;
        end
    end

    // output stage
    always_comb begin
        t_ctx        c;
        logic [32:0] sl;
        c  = r_pipe[LS-1];
        sl = sat32({2'b00, c.root});
        if (c.op == OP_DIST) begin
            c.res[0] = sl[31:0];
            c.ov     = c.ov | sl[32];
        end else if (c.op == OP_UNIT || c.op == OP_UNIT_DIFF) begin
            if (c.root == 64'd0) begin
                c.dz  = 1'b1;
                c.res = '0;
            end else begin
                for (int i = 0; i < 3; i++) begin
                    c.res[i] = c.v[i][31] ? 32'd0 - 32'(c.quo[i]) : 32'(c.quo[i]);
                end
            end
        end
        n_pipe[LS] = c;
    end

    assign o_valid        = r_vld[NST-1];
    assign o_res.res_x    = r_pipe[NST-1].res[0];
    assign o_res.res_y    = r_pipe[NST-1].res[1];
    assign o_res.res_z    = r_pipe[NST-1].res[2];
    assign o_res.overflow = r_pipe[NST-1].ov;
    assign o_res.div_zero = r_pipe[NST-1].dz;

    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid straight after reset");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("pipeline refuses input with an empty output");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.div_zero |->
            o_res.res_x == 32'sd0 && o_res.res_y == 32'sd0 && o_res.res_z == 32'sd0)
        else $error("div_zero with a non-zero vector");

    a_dz_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_res.div_zero |->
            r_pipe[NST-1].op == OP_UNIT || r_pipe[NST-1].op == OP_UNIT_DIFF)
        else $error("div_zero on an operation that does not normalise");

    a_scalar_yz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (r_pipe[NST-1].op == OP_DOT || r_pipe[NST-1].op == OP_DIST) |->
            o_res.res_y == 32'sd0 && o_res.res_z == 32'sd0)
        else $error("scalar result with non-zero y or z");

endmodule
